>>> sv/sih_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_pkg - shared definitions for the sorted insert store
// Sizes, cell link type, control state codes and the height clamp.
// ----------------------------------------------------------------------------
package sih_pkg;

    localparam int DEPTH    = 1024;
    localparam int LEVELS   = 20;
    localparam int VALUE_W  = 31;
    localparam int HEIGHT_W = 5;
    localparam int POS_W    = 11;

    localparam int LANES  = 32;
    localparam int LANE_W = $clog2(LANES);
    localparam int NGRP   = (DEPTH + LANES - 1) / LANES;
    localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int PAD_W  = NGRP * LANES;

    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [HEIGHT_W-1:0] height;
        logic                qual;
    } sih_link_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_ENCODE,
        ST_OUT
    } sih_state_t;

    typedef struct packed {
        logic s_ready;
        logic m_valid;
        logic shift_en;
        logic capture;
        logic load_out;
    } sih_ctrl_t;

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [HEIGHT_W-1:0] h);
        logic [HEIGHT_W-1:0] r;
        r = h;
        if (h == '0) begin
            r = HEIGHT_W'(1);
        end else if (h > HEIGHT_W'(LEVELS)) begin
            r = HEIGHT_W'(LEVELS);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/sih_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_cell - one slot of the sorted store
// Compares its value with the new one, then holds, takes the new value or
// takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module sih_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          shift_en,
    input  wire logic [sih_pkg::VALUE_W-1:0]   ins_value,
    input  wire logic [sih_pkg::HEIGHT_W-1:0]  ins_height,
    input  wire sih_pkg::sih_link_t            left,
    output sih_pkg::sih_link_t                 link,
    output logic                               hit
);
    import sih_pkg::*;

    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic                qual;

    assign qual = (value_reg == '0) || (value_reg >= ins_value);
    assign hit  = qual && !left.qual;

    always_comb begin
        value_next  = value_reg;
        height_next = height_reg;
        if (shift_en && qual) begin
            if (left.qual) begin
                value_next  = left.value;
                height_next = left.height;
            end else begin
                value_next  = ins_value;
                height_next = ins_height;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg  <= '0;
            height_reg <= '0;
        end else begin
            value_reg  <= value_next;
            height_reg <= height_next;
        end
    end

    assign link.value  = value_reg;
    assign link.height = height_reg;
    assign link.qual   = qual;

endmodule
`default_nettype wire

>>> sv/sih_encode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sih_encode - slot index of the insert point
// Folds the one-hot hit row into group and lane words, registers them,
// then encodes both into a slot index.
// ----------------------------------------------------------------------------
module sih_encode (
    input  wire logic                         aclk,
    input  wire logic                         capture,
    input  wire logic [sih_pkg::DEPTH-1:0]    hits,
    output logic      [sih_pkg::POS_W-1:0]    index
);
    import sih_pkg::*;

    logic [PAD_W-1:0] pad;
    logic [NGRP-1:0]  grp_or_next, grp_or_reg;
    logic [LANES-1:0] lane_or_next, lane_or_reg;
    logic [GRP_W-1:0] grp;
    logic [LANE_W-1:0] lane;

    assign pad = PAD_W'(hits);

    always_comb begin
        grp_or_next  = '0;
        lane_or_next = '0;
        for (int g = 0; g < NGRP; g++) begin
            grp_or_next[g] = |pad[g*LANES +: LANES];
            lane_or_next   = lane_or_next | pad[g*LANES +: LANES];
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            grp_or_reg  <= grp_or_next;
            lane_or_reg <= lane_or_next;
        end
    end

    always_comb begin
        grp  = '0;
        lane = '0;
        for (int g = 0; g < NGRP; g++) begin
            if (grp_or_reg[g]) begin
                grp = grp | GRP_W'(g);
            end
        end
        for (int j = 0; j < LANES; j++) begin
            if (lane_or_reg[j]) begin
                lane = lane | LANE_W'(j);
            end
        end
    end

    assign index = POS_W'({grp, lane});

endmodule
`default_nettype wire

>>> sv/sorted_insert_with_height.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insert_with_height - sorted value store with per-entry height
// A row of compare-and-shift cells keeps values ascending; each insert
// reports its slot and whether an entry was lost.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_new_value[30:0], s_tower_height[4:0]
// m_       out  m_valid/m_ready    m_insert_position[10:0], m_entry_dropped
//
// A beat passes in order through shift of the cell row, index encode, result beat.
// A new beat is taken while the result beat leaves, so one beat is in flight
// at a time; the index tree's register sets the encode cycle.
// Reset clears every cell; no input beat is taken during it.
// A stalled result holds the block.
// ----------------------------------------------------------------------------
module sorted_insert_with_height (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [sih_pkg::VALUE_W-1:0]   s_new_value,
    input  wire logic [sih_pkg::HEIGHT_W-1:0]  s_tower_height,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [sih_pkg::POS_W-1:0]     m_insert_position,
    output logic                               m_entry_dropped
);
    import sih_pkg::*;

    sih_state_t state_reg, state_next;
    sih_ctrl_t  ctrl;

    logic [VALUE_W-1:0]  value_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic zero_reg, none_reg, last_occ_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic drop_reg, drop_next;

    sih_link_t        links [DEPTH];
    sih_link_t        edge_link;
    logic [DEPTH-1:0] hits;
    logic [POS_W-1:0] index;
    logic             in_beat;

    assign in_beat = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SHIFT;
            ST_SHIFT:  state_next = ST_ENCODE;
            ST_ENCODE: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) state_next = s_valid ? ST_SHIFT : ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        ctrl = '0;
        case (state_reg)
            ST_IDLE:   ctrl.s_ready = 1'b1;
            ST_SHIFT: begin
                ctrl.shift_en = 1'b1;
                ctrl.capture  = 1'b1;
            end
            ST_ENCODE: ctrl.load_out = 1'b1;
            ST_OUT: begin
                ctrl.m_valid = 1'b1;
                ctrl.s_ready = m_ready;
            end
            default:   ctrl = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // hold the beat
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            value_reg  <= s_new_value;
            height_reg <= clamp_height(s_tower_height);
        end
        if (ctrl.capture) begin
            zero_reg     <= (value_reg == '0);
            none_reg     <= !links[DEPTH-1].qual;
            last_occ_reg <= (links[DEPTH-1].value != '0);
        end
        if (ctrl.load_out) begin
            pos_reg  <= pos_next;
            drop_reg <= drop_next;
        end
    end

    always_comb begin
        pos_next  = index;
        drop_next = last_occ_reg;
        if (zero_reg) begin
            pos_next  = POS_W'(DEPTH);
            drop_next = 1'b0;
        end else if (none_reg) begin
            pos_next  = POS_W'(DEPTH);
            drop_next = 1'b1;
        end
    end

    assign edge_link = '0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        sih_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .shift_en   (ctrl.shift_en && (value_reg != '0)),
            .ins_value  (value_reg),
            .ins_height (height_reg),
            .left       ((k == 0) ? edge_link : links[(k == 0) ? 0 : k - 1]),
            .link       (links[k]),
            .hit        (hits[k])
        );
    end

    sih_encode u_encode (
        .aclk    (aclk),
        .capture (ctrl.capture),
        .hits    (hits),
        .index   (index)
    );

    assign s_ready           = ctrl.s_ready && aresetn;
    assign m_valid           = ctrl.m_valid;
    assign m_insert_position = pos_reg;
    assign m_entry_dropped   = drop_reg;

    // the insert point is unique while the row is sorted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> $onehot0(hits))
        else $error("more than one insert point in the cell row");

    // empties only at the tail
    assert property (@(posedge aclk) disable iff (!aresetn)
        (links[DEPTH-1].value != '0) |-> (links[0].value != '0))
        else $error("occupied last slot with an empty first slot");

    // one beat in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input beat taken while an insert is in flight");

endmodule
`default_nettype wire
